[design/dpbd_pkg.sv]
// ----------------------------------------------------------------------------
// dpbd_pkg
// Shared types and constants of the DCF77 phase and bit decoder.
// ----------------------------------------------------------------------------
package dpbd_pkg;

    localparam int BINS_PER_SECOND = 100;
    localparam int SAMPLES_PER_BIN = 10;

    localparam int BIN_W  = 7;
    localparam int HS_W   = 4;
    localparam int HIST_W = 16;
    localparam int CORR_W = 32;
    localparam int WL_W   = 5;
    localparam int WC_W   = 7;

    // Bin offsets of the correlation taps and the noise sample.
    localparam int B10MS      = BINS_PER_SECOND / 100;
    localparam int START_OFS  = (10 - 2) * 10 * B10MS;
    localparam int MIDDLE_OFS = (10 - 1) * 10 * B10MS;
    localparam int NOISE_OFS  = 2 * 20 * B10MS;

    // Symbol window.
    localparam int WIN_LEN     = 20 * B10MS + 2 * B10MS;
    localparam int WIN_HALF    = 10 * B10MS;
    localparam int WIN_AFTER   = 10 * B10MS;
    localparam int WIN_BEFORE  = B10MS;
    localparam int HALF_THRESH = SAMPLES_PER_BIN * 5 * B10MS;

    localparam logic [1:0] SYM_SYNC = 2'd0;
    localparam logic [1:0] SYM_ZERO = 2'd2;

    localparam int          REG_BIN_CEILING   = 0;
    localparam logic [15:0] BIN_CEILING_RESET = 16'd3000;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef struct packed {
        logic [BIN_W-1:0] bin_index;
        logic [HS_W-1:0]  high_samples;
    } t_in_item;

    typedef struct packed {
        logic                     symbol_valid;
        logic [1:0]               symbol;
        logic [BIN_W-1:0]         phase;
        logic signed [CORR_W-1:0] signal_peak;
        logic signed [CORR_W-1:0] noise_level;
    } t_result;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic             in_range;
        logic [BIN_W-1:0] tick;
        logic [HS_W-1:0]  hs;
        logic [BIN_W-1:0] start;
        logic [BIN_W-1:0] middle;
    } t_cls;

endpackage

[design/dpbd_ram.sv]
// ----------------------------------------------------------------------------
// dpbd_ram
// Generic one-write, one-read RAM with registered read (old data on collision).
// ----------------------------------------------------------------------------
module dpbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/dpbd_front.sv]
// ----------------------------------------------------------------------------
// dpbd_front
// Accept bins, classify them and hold them in a two-entry queue for the back.
// ----------------------------------------------------------------------------
module dpbd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dpbd_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_cls_valid,
    output dpbd_pkg::t_cls    o_cls
);

    dpbd_pkg::t_cls r_q [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_cnt;
    dpbd_pkg::t_cls w_cls;
    logic           w_push, w_pop;

    // Classify: range check, clamp, correlation tap addresses.
    always_comb begin
        w_cls.tick     = i_item.bin_index;
        w_cls.in_range = i_item.bin_index < dpbd_pkg::BIN_W'(dpbd_pkg::BINS_PER_SECOND);
        w_cls.hs       = (i_item.high_samples > dpbd_pkg::HS_W'(dpbd_pkg::SAMPLES_PER_BIN))
                         ? dpbd_pkg::HS_W'(dpbd_pkg::SAMPLES_PER_BIN) : i_item.high_samples;
        if (i_item.bin_index >=
            dpbd_pkg::BIN_W'(dpbd_pkg::BINS_PER_SECOND - dpbd_pkg::START_OFS)) begin
            w_cls.start = i_item.bin_index
                          - dpbd_pkg::BIN_W'(dpbd_pkg::BINS_PER_SECOND - dpbd_pkg::START_OFS);
        end else begin
            w_cls.start = i_item.bin_index + dpbd_pkg::BIN_W'(dpbd_pkg::START_OFS);
        end
        if (i_item.bin_index >=
            dpbd_pkg::BIN_W'(dpbd_pkg::BINS_PER_SECOND - dpbd_pkg::MIDDLE_OFS)) begin
            w_cls.middle = i_item.bin_index
                           - dpbd_pkg::BIN_W'(dpbd_pkg::BINS_PER_SECOND - dpbd_pkg::MIDDLE_OFS);
        end else begin
            w_cls.middle = i_item.bin_index + dpbd_pkg::BIN_W'(dpbd_pkg::MIDDLE_OFS);
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cls_valid = (r_cnt != 2'd0);
    assign o_cls       = r_q[r_rd_ptr];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_pop && o_cls_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cls;
        end
    end

endmodule

[design/dpbd_back.sv]
// ----------------------------------------------------------------------------
// dpbd_back
// Histogram update, running correlation, peak and noise tracking, symbol window.
// ----------------------------------------------------------------------------
module dpbd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [15:0]                     i_ceiling,
    input  logic                            i_cls_valid,
    input  dpbd_pkg::t_cls                  i_cls,
    output logic                            o_issue,
    input  logic [dpbd_pkg::OUT_CNT_W-1:0]  i_out_count,
    output logic                            o_res_push,
    output dpbd_pkg::t_result               o_res
);

    localparam int BW = dpbd_pkg::BIN_W;
    localparam int HW = dpbd_pkg::HIST_W;
    localparam int CW = dpbd_pkg::CORR_W;

    // Read stage -> execute stage
    logic                r_e_valid;
    dpbd_pkg::t_cls      r_e;
    logic [dpbd_pkg::BINS_PER_SECOND-1:0] r_hvalid;
    logic                r_v_tick, r_v_start, r_v_mid;
    logic [HW-1:0]       w_rd_tick, w_rd_start, w_rd_mid;

    // Last histogram write, for forwarding
    logic                r_lw_valid;
    logic [BW-1:0]       r_lw_addr;
    logic [HW-1:0]       r_lw_data;

    // Tracking state
    logic [CW-1:0]       r_corr, r_peak, r_noise, r_peak_reg, r_noise_reg;
    logic [BW-1:0]       r_pidx, r_phase;
    logic [dpbd_pkg::WL_W-1:0] r_wl;
    logic [dpbd_pkg::WC_W-1:0] r_wc;
    logic [1:0]          r_partial;

    logic [CW-1:0]       n_corr, n_peak, n_noise, n_peak_reg, n_noise_reg;
    logic [BW-1:0]       n_pidx, n_phase;
    logic [dpbd_pkg::WL_W-1:0] n_wl;
    logic [dpbd_pkg::WC_W-1:0] n_wc;
    logic [1:0]          n_partial;

    logic [HW-1:0]       w_hb, w_hstart, w_hmid, w_b1, w_b2, w_leak;
    logic [HW:0]         w_bsum;
    logic [BW-1:0]       w_noise_idx, w_after, w_before;
    logic                w_we, w_sym_valid;
    logic [1:0]          w_sym;

    // Issue a read only with room for its result in the result queue.
    assign o_issue = i_cls_valid &&
                     ({1'b0, i_out_count} + {{dpbd_pkg::OUT_CNT_W{1'b0}}, r_e_valid}
                      < (dpbd_pkg::OUT_CNT_W+1)'(dpbd_pkg::OUT_DEPTH));

    dpbd_ram #(.WIDTH(HW), .DEPTH(dpbd_pkg::BINS_PER_SECOND)) u_ram_tick (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_e.tick), .i_wdata(w_b2),
        .i_re(o_issue), .i_raddr(i_cls.tick), .o_rdata(w_rd_tick)
    );
    dpbd_ram #(.WIDTH(HW), .DEPTH(dpbd_pkg::BINS_PER_SECOND)) u_ram_start (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_e.tick), .i_wdata(w_b2),
        .i_re(o_issue), .i_raddr(i_cls.start), .o_rdata(w_rd_start)
    );
    dpbd_ram #(.WIDTH(HW), .DEPTH(dpbd_pkg::BINS_PER_SECOND)) u_ram_mid (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_e.tick), .i_wdata(w_b2),
        .i_re(o_issue), .i_raddr(i_cls.middle), .o_rdata(w_rd_mid)
    );

    assign w_we = r_e_valid && r_e.in_range;

    always_comb begin
        // Forward last write; never-written bins read as zero.
        w_hb     = (r_lw_valid && r_lw_addr == r_e.tick)   ? r_lw_data :
                   (r_v_tick  ? w_rd_tick  : '0);
        w_hstart = (r_lw_valid && r_lw_addr == r_e.start)  ? r_lw_data :
                   (r_v_start ? w_rd_start : '0);
        w_hmid   = (r_lw_valid && r_lw_addr == r_e.middle) ? r_lw_data :
                   (r_v_mid   ? w_rd_mid   : '0);

        // Grow below the ceiling (saturating), then leak by the low count.
        w_bsum = {1'b0, w_hb} + (HW+1)'(r_e.hs);
        if (w_hb < i_ceiling) begin
            w_b1 = w_bsum[HW] ? {HW{1'b1}} : w_bsum[HW-1:0];
        end else begin
            w_b1 = w_hb;
        end
        w_leak = HW'(dpbd_pkg::SAMPLES_PER_BIN) - HW'(r_e.hs);
        w_b2   = (w_b1 > w_leak) ? (w_b1 - w_leak) : w_b1;

        if (r_phase >= BW'(dpbd_pkg::BINS_PER_SECOND - dpbd_pkg::NOISE_OFS)) begin
            w_noise_idx = r_phase - BW'(dpbd_pkg::BINS_PER_SECOND - dpbd_pkg::NOISE_OFS);
        end else begin
            w_noise_idx = r_phase + BW'(dpbd_pkg::NOISE_OFS);
        end

        n_corr      = r_corr;
        n_peak      = r_peak;
        n_pidx      = r_pidx;
        n_noise     = r_noise;
        n_phase     = r_phase;
        n_peak_reg  = r_peak_reg;
        n_noise_reg = r_noise_reg;
        n_wl        = r_wl;
        n_wc        = r_wc;
        n_partial   = r_partial;
        w_sym_valid = 1'b0;
        w_sym       = dpbd_pkg::SYM_SYNC;
        w_after     = '0;
        w_before    = '0;

        if (r_e.in_range) begin
            if ($signed(r_corr) > $signed(r_peak)) begin
                n_peak = r_corr;
                n_pidx = r_e.start;
            end
            if (r_e.tick == w_noise_idx) begin
                n_noise = r_corr;
            end
            if (r_e.tick == '0) begin
                n_peak_reg  = n_peak;
                n_noise_reg = n_noise;
                n_phase     = n_pidx;
                n_peak      = '0;
            end

            n_corr = r_corr - {{(CW-HW-1){1'b0}}, w_hstart, 1'b0}
                     + CW'(w_hmid) + CW'(w_b2);

            // Distances from the phase, both ways around the frame.
            if (r_e.tick >= n_phase) begin
                w_after = r_e.tick - n_phase;
            end else begin
                w_after = r_e.tick + BW'(dpbd_pkg::BINS_PER_SECOND) - n_phase;
            end
            if (n_phase >= r_e.tick) begin
                w_before = n_phase - r_e.tick;
            end else begin
                w_before = n_phase + BW'(dpbd_pkg::BINS_PER_SECOND) - r_e.tick;
            end

            if (r_wl == '0 && (w_after <= BW'(dpbd_pkg::WIN_AFTER)
                               || w_before <= BW'(dpbd_pkg::WIN_BEFORE))) begin
                n_wl = dpbd_pkg::WL_W'(dpbd_pkg::WIN_LEN);
            end

            if (n_wl != '0) begin
                n_wl = n_wl - 1'b1;
                n_wc = r_wc + dpbd_pkg::WC_W'(r_e.hs);
                if (n_wl > dpbd_pkg::WL_W'(dpbd_pkg::WIN_HALF)) begin
                    if (n_wl == dpbd_pkg::WL_W'(dpbd_pkg::WIN_HALF + 1)) begin
                        n_partial = (n_wc > dpbd_pkg::WC_W'(dpbd_pkg::HALF_THRESH))
                                    ? dpbd_pkg::SYM_ZERO : dpbd_pkg::SYM_SYNC;
                        n_wc      = '0;
                    end
                end else if (n_wl == '0) begin
                    if (n_wc > dpbd_pkg::WC_W'(dpbd_pkg::HALF_THRESH)) begin
                        n_partial = n_partial + 2'd1;
                    end
                    n_wc        = '0;
                    w_sym_valid = 1'b1;
                    w_sym       = n_partial;
                end
            end
        end
    end

    assign o_res_push         = r_e_valid;
    assign o_res.symbol_valid = w_sym_valid;
    assign o_res.symbol       = w_sym;
    assign o_res.phase        = n_phase;
    assign o_res.signal_peak  = n_peak_reg;
    assign o_res.noise_level  = n_noise_reg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid   <= 1'b0;
            r_lw_valid  <= 1'b0;
            r_hvalid    <= '0;
            r_corr      <= '0;
            r_peak      <= '0;
            r_pidx      <= '0;
            r_noise     <= '0;
            r_phase     <= '0;
            r_peak_reg  <= '0;
            r_noise_reg <= '0;
            r_wl        <= '0;
            r_wc        <= '0;
            r_partial   <= 2'd0;
        end else begin
            r_e_valid  <= o_issue;
            r_lw_valid <= w_we;
            if (w_we) begin
                r_hvalid[r_e.tick] <= 1'b1;
            end
            if (r_e_valid) begin
                r_corr      <= n_corr;
                r_peak      <= n_peak;
                r_pidx      <= n_pidx;
                r_noise     <= n_noise;
                r_phase     <= n_phase;
                r_peak_reg  <= n_peak_reg;
                r_noise_reg <= n_noise_reg;
                r_wl        <= n_wl;
                r_wc        <= n_wc;
                r_partial   <= n_partial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_issue) begin
            r_e       <= i_cls;
            r_v_tick  <= r_hvalid[i_cls.tick];
            r_v_start <= r_hvalid[i_cls.start];
            r_v_mid   <= r_hvalid[i_cls.middle];
        end
        if (w_we) begin
            r_lw_addr <= r_e.tick;
            r_lw_data <= w_b2;
        end
    end

endmodule

[design/dpbd_out_queue.sv]
// ----------------------------------------------------------------------------
// dpbd_out_queue
// Result queue between the back and the result ports.
// ----------------------------------------------------------------------------
module dpbd_out_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  dpbd_pkg::t_result              i_res,
    input  logic                           i_pop,
    output logic                           o_empty,
    output dpbd_pkg::t_result              o_res,
    output logic [dpbd_pkg::OUT_CNT_W-1:0] o_count
);

    dpbd_pkg::t_result                r_q [dpbd_pkg::OUT_DEPTH];
    logic [dpbd_pkg::OUT_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [dpbd_pkg::OUT_CNT_W-1:0]   r_cnt;
    logic                             w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_rd_ptr];
    assign o_count = r_cnt;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

endmodule

[design/dcf77_phase_and_bit_decoder_core.sv]
// ----------------------------------------------------------------------------
// dcf77_phase_and_bit_decoder_core
// DCF77 second-phase detector and per-second symbol decoder.
// ----------------------------------------------------------------------------
// Push one 10 ms bin per item (bin index and high sample count); every item
// yields exactly one result, in order, carrying the latched phase, peak and
// noise and, once per second, a decoded symbol. The block sustains one item
// per clock while the result queue has room: an item waits in the front queue,
// then reads the three histogram taps (the bin itself, 800 ms ahead, 900 ms
// ahead) from three registered-read RAM copies, then passes the execute stage,
// where the bin update, correlation, peak/noise tracking and symbol window all
// complete, and its result is then registered into the result queue.
// The execute stage forwards its own last histogram write, so back-to-back
// bins never see stale data. The histogram starts cleared through per-bin
// valid bits, so no clearing pass follows reset. Write bin_ceiling at byte
// address 0 only while the block is idle.
// ----------------------------------------------------------------------------
module dcf77_phase_and_bit_decoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Bin items
    input  logic                push,
    input  dpbd_pkg::t_in_item  i_item,
    output logic                full,
    // Results
    output logic                empty,
    input  logic                pop,
    output dpbd_pkg::t_result   o_result
);

    logic [15:0]                     r_bin_ceiling;
    logic                            w_cfg_wr, w_reg_sel;
    logic                            w_cls_valid, w_issue, w_res_push;
    dpbd_pkg::t_cls                  w_cls;
    dpbd_pkg::t_result               w_res;
    logic [dpbd_pkg::OUT_CNT_W-1:0]  w_out_cnt;

    // Register decode: word index sits above the byte offset.
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == 1'(dpbd_pkg::REG_BIN_CEILING));
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = w_reg_sel ? {16'd0, r_bin_ceiling} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_ceiling <= dpbd_pkg::BIN_CEILING_RESET;
        end else if (w_cfg_wr && w_reg_sel) begin
            r_bin_ceiling <= pwdata[15:0];
        end
    end

    // Front: accept and classify bins.
    dpbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_pop       (w_issue),
        .o_cls_valid (w_cls_valid),
        .o_cls       (w_cls)
    );

    // Back: histogram, correlation, window; issues only with result room.
    dpbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ceiling   (r_bin_ceiling),
        .i_cls_valid (w_cls_valid),
        .i_cls       (w_cls),
        .o_issue     (w_issue),
        .i_out_count (w_out_cnt),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // Result queue decouples the back from the consumer.
    dpbd_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (o_result),
        .o_count (w_out_cnt)
    );

    // The credit check must keep the result queue from overflowing.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_push && w_out_cnt == dpbd_pkg::OUT_CNT_W'(dpbd_pkg::OUT_DEPTH)))
        else $error("result queue overflow");

    // The back only takes an item the front actually holds.
    a_issue_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> w_cls_valid)
        else $error("issue from empty front queue");

    // A ceiling write lands in the register on the next cycle.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && w_reg_sel) |=> (r_bin_ceiling == $past(pwdata[15:0])))
        else $error("bin ceiling write lost");

endmodule

[sim/dcf77_decoder_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dcf77_decoder_check
// Bin-by-bin prediction and result checking for the DCF77 phase and bit decoder.
// ----------------------------------------------------------------------------
// Tracks bin_ceiling from configuration writes and checks read-back. Runs its
// own histogram, correlation, peak/noise tracking and symbol window on every
// accepted bin, queues the expected result, and compares each popped result
// field by field. Failures, results due, and coverage counts go to the top.
// ----------------------------------------------------------------------------
module dcf77_decoder_check
    import dpbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    input  logic        i_push,
    input  logic        i_full,
    input  t_in_item    i_item,
    input  logic        i_pop,
    input  logic        i_empty,
    input  t_result     i_result,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_checked,
    output int          o_symbols_seen
);

    localparam logic [2:0] CEILING_ADDR = 3'(REG_BIN_CEILING * 4);

    logic [HIST_W-1:0] bin_hist [BINS_PER_SECOND];
    logic [CORR_W-1:0] corr_sum;
    logic [CORR_W-1:0] peak_run;
    logic [BIN_W-1:0]  peak_run_bin;
    logic [CORR_W-1:0] noise_run;
    logic [BIN_W-1:0]  phase_held;
    logic [CORR_W-1:0] peak_held;
    logic [CORR_W-1:0] noise_held;
    logic [WL_W-1:0]   win_left;
    logic [WC_W-1:0]   win_count;
    logic [1:0]        half_symbol;
    logic [15:0]       ceiling;
    t_result           due_results [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < 40)
            $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        o_fail_count++;
    endtask

    // Advance the decoder by one bin and return the result it produces.
    function automatic t_result decode_bin(input t_in_item it);
        int      tick;
        int      hs;
        int      start_bin;
        int      middle_bin;
        int      level;
        int      leak;
        int      lag;
        int      lead;
        t_result r;

        r    = '0;
        tick = it.bin_index;
        hs   = it.high_samples;
        if (tick < BINS_PER_SECOND) begin
            if (hs > SAMPLES_PER_BIN)
                hs = SAMPLES_PER_BIN;
            start_bin  = (tick + START_OFS) % BINS_PER_SECOND;
            middle_bin = (tick + MIDDLE_OFS) % BINS_PER_SECOND;

            // Grow below the ceiling with saturation, then leak by the low count.
            level = bin_hist[tick];
            if (level < ceiling) begin
                level = level + hs;
                if (level > 65535)
                    level = 65535;
            end
            leak = SAMPLES_PER_BIN - hs;
            if (level > leak)
                level = level - leak;
            bin_hist[tick] = 16'(level);

            if ($signed(corr_sum) > $signed(peak_run)) begin
                peak_run     = corr_sum;
                peak_run_bin = 7'(start_bin);
            end
            if (tick == (phase_held + NOISE_OFS) % BINS_PER_SECOND)
                noise_run = corr_sum;

            if (tick == 0) begin
                peak_held  = peak_run;
                noise_held = noise_run;
                phase_held = peak_run_bin;
                peak_run   = '0;
            end

            corr_sum = corr_sum - 32'(2 * bin_hist[start_bin])
                     + 32'(bin_hist[middle_bin]) + 32'(level);

            if (win_left == 0) begin
                lag  = (BINS_PER_SECOND + tick - phase_held) % BINS_PER_SECOND;
                lead = (BINS_PER_SECOND + phase_held - tick) % BINS_PER_SECOND;
                if (lag <= WIN_AFTER || lead <= WIN_BEFORE)
                    win_left = WL_W'(WIN_LEN);
            end

            if (win_left > 0) begin
                win_left  = win_left - 1'b1;
                win_count = win_count + WC_W'(hs);
                if (win_left > WIN_HALF) begin
                    if (win_left == WIN_HALF + 1) begin
                        half_symbol = (win_count > HALF_THRESH) ? SYM_ZERO : SYM_SYNC;
                        win_count   = '0;
                    end
                end else if (win_left == 0) begin
                    if (win_count > HALF_THRESH)
                        half_symbol = half_symbol + 2'd1;
                    win_count      = '0;
                    r.symbol_valid = 1'b1;
                    r.symbol       = half_symbol;
                end
            end
        end
        r.phase       = phase_held;
        r.signal_peak = peak_held;
        r.noise_level = noise_held;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < BINS_PER_SECOND; k++)
                bin_hist[k] = '0;
            corr_sum     = '0;
            peak_run     = '0;
            peak_run_bin = '0;
            noise_run    = '0;
            phase_held   = '0;
            peak_held    = '0;
            noise_held   = '0;
            win_left     = '0;
            win_count    = '0;
            half_symbol  = '0;
            ceiling      = BIN_CEILING_RESET;
            due_results.delete();
            o_pending <= 0;
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == CEILING_ADDR) begin
                if (i_pwrite)
                    ceiling = i_pwdata[15:0];
                else if (i_prdata !== {16'b0, ceiling})
                    report_mismatch("bin_ceiling read", i_prdata, {16'b0, ceiling});
            end
            if (i_push && !i_full)
                due_results.push_back(decode_bin(i_item));
            if (i_pop && !i_empty) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with none due", 32'(i_result.phase), '0);
                end else begin
                    want = due_results.pop_front();
                    if (i_result.symbol_valid !== want.symbol_valid)
                        report_mismatch("symbol_valid", 32'(i_result.symbol_valid),
                                        32'(want.symbol_valid));
                    if (i_result.symbol !== want.symbol)
                        report_mismatch("symbol", 32'(i_result.symbol), 32'(want.symbol));
                    if (i_result.phase !== want.phase)
                        report_mismatch("phase", 32'(i_result.phase), 32'(want.phase));
                    if (i_result.signal_peak !== want.signal_peak)
                        report_mismatch("signal_peak", i_result.signal_peak,
                                        want.signal_peak);
                    if (i_result.noise_level !== want.noise_level)
                        report_mismatch("noise_level", i_result.noise_level,
                                        want.noise_level);
                    o_results_checked++;
                    if (want.symbol_valid)
                        o_symbols_seen++;
                end
            end
            o_pending <= due_results.size();
        end
    end

endmodule

[sim/dcf77_phase_and_bit_decoder_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dcf77_phase_and_bit_decoder_core_tb
// Randomized bin stream test of the DCF77 phase and bit decoder.
// ----------------------------------------------------------------------------
// Feeds bin items through the push/full queue and drains results through
// empty/pop, both with random gaps. Runs directed extremes, several
// bin_ceiling settings with mostly well-formed one-second frames, and a long
// run that saturates a bin and wraps the correlation sum. A side checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module dcf77_phase_and_bit_decoder_core_tb;
    import dpbd_pkg::*;

    localparam logic [2:0] CEILING_ADDR    = 3'(REG_BIN_CEILING * 4);
    localparam int         SEGMENT_BINS    = 250;
    localparam int         RX_HOLD_CYCLES  = 300;
    localparam int         SATURATE_PUSHES = 6600;
    localparam int         WRAP_PUSHES     = 20000;
    localparam int         END_WAIT_LIMIT  = 20000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push    = 1'b0;
    t_in_item    bin_item = '0;
    logic        full;
    logic        empty;
    logic        pop     = 1'b0;
    t_result     bin_result;

    int fail_count;
    int pending;
    int results_checked;
    int symbols_seen;

    // Stimulus bookkeeping and the handshake between sender and receiver.
    int       bins_in_range = 0;
    int       bins_ignored  = 0;
    int       next_tick     = 0;
    int       pulse_bin     = 0;
    logic [1:0] sec_symbol  = SYM_ZERO;
    bit       rx_hold_req   = 1'b0;
    bit       rx_quick      = 1'b0;

    always #6 i_clk = ~i_clk;

    dcf77_phase_and_bit_decoder_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .push     (push),
        .i_item   (bin_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (bin_result)
    );

    dcf77_decoder_check u_decode_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_prdata          (prdata),
        .i_pready          (pready),
        .i_push            (push),
        .i_full            (full),
        .i_item            (bin_item),
        .i_pop             (pop),
        .i_empty           (empty),
        .i_result          (bin_result),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked),
        .o_symbols_seen    (symbols_seen)
    );

    // Mostly back-to-back, sometimes a short gap, rarely a long gap.
    // Quick mode only drops the odd single cycle.
    function automatic int pick_gap(input bit quick);
        int r;
        if (quick)
            return ($urandom_range(0, 9) == 0) ? 1 : 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one bin and hold it until the block takes it. push stays high
    // afterwards so the next bin can follow without a bubble.
    task automatic send_bin(input logic [BIN_W-1:0] idx, input logic [HS_W-1:0] hs,
                            input bit quick);
        int       gap;
        t_in_item nxt;
        gap = quick ? 0 : pick_gap(1'b0);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        nxt.bin_index    = idx;
        nxt.high_samples = hs;
        push     <= 1'b1;
        bin_item <= nxt;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (idx < BINS_PER_SECOND)
            bins_in_range++;
        else
            bins_ignored++;
    endtask

    // Hold the sender until every result due has been popped. The first edge
    // lets the pending count pick up the last accepted bin.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Change the ceiling only with the block idle, then read it back.
    task automatic write_ceiling(input logic [15:0] value);
        drain_results();
        apb_access(1'b1, CEILING_ADDR, {16'b0, value});
        apb_access(1'b0, CEILING_ADDR, '0);
    endtask

    // Send consecutive bins of a DCF77-like second. The pulse starts at
    // pulse_bin; its first 100 ms is high for a zero/one and low for a sync
    // mark, the second 100 ms is high for a one. Sprinkle raw noise on top.
    task automatic send_frame_run(input int len);
        int         d;
        int         r;
        logic [3:0] hs;
        for (int k = 0; k < len; k++) begin
            d = (next_tick + BINS_PER_SECOND - pulse_bin) % BINS_PER_SECOND;
            if (d == 0) begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    sec_symbol = SYM_SYNC;
                else if (r == 1)
                    sec_symbol = SYM_SYNC + 2'd1;
                else
                    sec_symbol = SYM_ZERO + 2'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 24) == 0)
                hs = 4'($urandom_range(0, 15));
            else if (d < 10)
                hs = sec_symbol[1] ? 4'($urandom_range(8, 10)) : 4'($urandom_range(0, 2));
            else if (d < 20)
                hs = sec_symbol[0] ? 4'($urandom_range(8, 10)) : 4'($urandom_range(0, 2));
            else
                hs = 4'($urandom_range(0, 2));
            send_bin(7'(next_tick), hs, 1'b0);
            next_tick = (next_tick + 1) % BINS_PER_SECOND;
        end
    endtask

    // Mostly whole seconds; some noise bursts with any index or count, some
    // broken seconds that jump to a random bin and stop early.
    task automatic run_segment(input int quota);
        int first_count;
        int r;
        first_count = bins_in_range;
        while (bins_in_range - first_count < quota) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                send_frame_run(BINS_PER_SECOND);
            end else if (r < 88) begin
                repeat ($urandom_range(1, 20))
                    send_bin(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)), 1'b0);
            end else begin
                next_tick = $urandom_range(0, BINS_PER_SECOND - 1);
                send_frame_run($urandom_range(5, 40));
            end
        end
    endtask

    // Receiver: pop with random gaps; on request stall for a long stretch so
    // the output queue fills and the block pushes back on its input.
    initial begin : result_sink
        int idle_left;
        idle_left = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                pop <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_left > 0) begin
                pop <= 1'b0;
                idle_left--;
            end else begin
                pop <= 1'b1;
                idle_left = pick_gap(rx_quick);
            end
        end
    end

    initial begin : stimulus
        logic [15:0] ceil_val;
        int          end_wait;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset value of the ceiling must read back.
        apb_access(1'b0, CEILING_ADDR, '0);

        // Directed: ignored indexes, clamped counts, field extremes, then one
        // full symbol window opened at bin 99, just ahead of the reset phase (bin 0), with
        // both halves high, which decodes as a one.
        send_bin(7'd127, 4'd15, 1'b0);
        send_bin(7'd100, 4'd0, 1'b0);
        send_bin(7'd50, 4'd11, 1'b0);
        send_bin(7'd63, 4'd0, 1'b0);
        send_bin(7'd99, 4'd10, 1'b0);
        for (int t = 0; t <= 20; t++)
            send_bin(7'(t), (t < 10) ? 4'd10 : 4'd6, 1'b0);

        // Random frames under several ceilings, extremes first.
        for (int seg = 0; seg < 5; seg++) begin
            case (seg)
                0:       ceil_val = 16'd1;
                1:       ceil_val = 16'hFFFF;
                2:       ceil_val = BIN_CEILING_RESET;
                3:       ceil_val = 16'd2;
                default: ceil_val = 16'($urandom_range(1, 65535));
            endcase
            write_ceiling(ceil_val);
            pulse_bin = $urandom_range(0, BINS_PER_SECOND - 1);
            // Stall the receiver while frames keep coming.
            if (seg == 1)
                rx_hold_req = 1'b1;
            run_segment(SEGMENT_BINS);
        end

        // Long haul with the ceiling open: drive one bin to saturation, nudge it
        // below the top and back so the clamp engages, then hammer the bin whose
        // 800 ms tap is that bin until the correlation sum wraps.
        write_ceiling(16'hFFFF);
        rx_quick = 1'b1;
        repeat (SATURATE_PUSHES) send_bin(7'd17, 4'd10, 1'b1);
        repeat (3) begin
            send_bin(7'd17, 4'd9, 1'b1);
            send_bin(7'd17, 4'd10, 1'b1);
        end
        repeat (WRAP_PUSHES) send_bin(7'd37, 4'd0, 1'b1);
        rx_quick = 1'b0;

        // Back to frames with a small random ceiling and the saturated bin in place.
        write_ceiling(16'($urandom_range(20, 500)));
        pulse_bin = $urandom_range(0, BINS_PER_SECOND - 1);
        run_segment(SEGMENT_BINS);

        // Drain with a bound, then let the pipeline settle.
        push <= 1'b0;
        @(posedge i_clk);
        end_wait = 0;
        while (pending != 0 && end_wait < END_WAIT_LIMIT) begin
            @(posedge i_clk);
            end_wait++;
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bins in range and %0d ignored; checked %0d results, %0d symbols",
                 bins_in_range, bins_ignored, results_checked, symbols_seen);
        $display("Ceilings 1..65535, output stall, bin saturation, correlation wrap; %0d left due",
                 pending);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
